### rtl/cau_pkg.sv
package cau_pkg;

  localparam int unsigned WidthDefault    = 16;
  localparam int unsigned FracBitsDefault = 8;

  localparam int unsigned OpW = 3;
  localparam int unsigned StW = 2;

  localparam logic [OpW-1:0] OP_ADD   = 3'd0;
  localparam logic [OpW-1:0] OP_MUL   = 3'd1;
  localparam logic [OpW-1:0] OP_CONJ  = 3'd2;
  localparam logic [OpW-1:0] OP_MOD   = 3'd3;
  localparam logic [OpW-1:0] OP_RECIP = 3'd4;

  localparam logic [StW-1:0] ST_OK   = 2'd0;
  localparam logic [StW-1:0] ST_DIVZ = 2'd1;
  localparam logic [StW-1:0] ST_SAT  = 2'd2;

endpackage

### rtl/cau_cell.sv
module cau_cell #(
  parameter int unsigned NC = 32,
  parameter int unsigned SW = 32
) (
  input  logic            clk_i,
  input  logic [SW-1:0]   div_s_i,
  input  logic [NC-1:0]   re_n_i,
  input  logic [SW-1:0]   re_r_i,
  input  logic [NC-1:0]   re_q_i,
  input  logic [NC-1:0]   im_n_i,
  input  logic [SW-1:0]   im_r_i,
  input  logic [NC-1:0]   im_q_i,
  input  logic [2*NC-1:0] sq_n_i,
  input  logic [NC:0]     sq_r_i,
  input  logic [NC-1:0]   sq_q_i,
  output logic [SW-1:0]   div_s_o,
  output logic [NC-1:0]   re_n_o,
  output logic [SW-1:0]   re_r_o,
  output logic [NC-1:0]   re_q_o,
  output logic [NC-1:0]   im_n_o,
  output logic [SW-1:0]   im_r_o,
  output logic [NC-1:0]   im_q_o,
  output logic [2*NC-1:0] sq_n_o,
  output logic [NC:0]     sq_r_o,
  output logic [NC-1:0]   sq_q_o
);

  logic [SW:0]   re_rs, im_rs, re_df, im_df;
  logic          re_ge, im_ge, sq_ge;
  logic [NC+2:0] sq_rs, sq_t, sq_df;

  // one restoring divide bit per part, one root bit
  always_comb begin
    re_rs = {re_r_i, re_n_i[NC-1]};
    im_rs = {im_r_i, im_n_i[NC-1]};
    re_df = re_rs - {1'b0, div_s_i};
    im_df = im_rs - {1'b0, div_s_i};
    re_ge = re_rs >= {1'b0, div_s_i};
    im_ge = im_rs >= {1'b0, div_s_i};
    sq_rs = {sq_r_i, sq_n_i[2*NC-1 -: 2]};
    sq_t  = {1'b0, sq_q_i, 2'b01};
    sq_df = sq_rs - sq_t;
    sq_ge = sq_rs >= sq_t;
  end

  always_ff @(posedge clk_i) begin
    div_s_o <= div_s_i;
    re_n_o  <= {re_n_i[NC-2:0], 1'b0};
    im_n_o  <= {im_n_i[NC-2:0], 1'b0};
    re_r_o  <= re_ge ? re_df[SW-1:0] : re_rs[SW-1:0];
    im_r_o  <= im_ge ? im_df[SW-1:0] : im_rs[SW-1:0];
    re_q_o  <= {re_q_i[NC-2:0], re_ge};
    im_q_o  <= {im_q_i[NC-2:0], im_ge};
    sq_n_o  <= {sq_n_i[2*NC-3:0], 2'b00};
    sq_r_o  <= sq_ge ? sq_df[NC:0] : sq_rs[NC:0];
    sq_q_o  <= {sq_q_i[NC-2:0], sq_ge};
  end

endmodule

### rtl/complex_arithmetic_unit.sv
// complex arithmetic unit, signed fixed point (WIDTH bits, FRAC_BITS fraction bits).
// a word is taken on every clock edge with start_i high (busy_o never rises), so one
// request per cycle is sustained. each result appears on res_re_o/res_im_o/status_o
// for one cycle with done_o high, in request order; the receiver cannot stall it.
// the default format is Q8.8. a request passes an operand register, a multiply stage
// and a sum stage, then the chain of WIDTH+2*FRAC_BITS cells, each producing one
// quotient bit of both reciprocal parts and one bit of the modulus square root,
// then the output register. status: 0 ok, 1 reciprocal of zero, 2 saturated.
module complex_arithmetic_unit #(
  parameter int unsigned WIDTH     = cau_pkg::WidthDefault,
  parameter int unsigned FRAC_BITS = cau_pkg::FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [cau_pkg::OpW-1:0]  req_type_i,
  input  logic signed [WIDTH-1:0]  a_re_i,
  input  logic signed [WIDTH-1:0]  a_im_i,
  input  logic signed [WIDTH-1:0]  b_re_i,
  input  logic signed [WIDTH-1:0]  b_im_i,
  output logic                     done_o,
  output logic signed [WIDTH-1:0]  res_re_o,
  output logic signed [WIDTH-1:0]  res_im_o,
  output logic [cau_pkg::StW-1:0]  status_o
);
  import cau_pkg::*;

  localparam int unsigned W   = WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned SW  = 2 * W;          // sum of squares
  localparam int unsigned NC  = W + 2 * F;      // cells in the chain
  localparam int unsigned LAT = NC + 4;

  localparam logic signed [W:0]   VMAX1  = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0]   VMIN1  = {2'b11, {(W-1){1'b0}}};
  localparam logic signed [2*W:0] VMAX2  = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W:0] VMIN2  = {{(W+2){1'b1}}, {(W-1){1'b0}}};
  localparam logic [NC-1:0]       RMAX   = {{(NC-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NC-1:0]       RNEG   = RMAX + 1'b1;
  localparam logic [W-1:0]        WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]        WMIN   = {1'b1, {(W-1){1'b0}}};

  // request is always taken
  assign busy_o = 1'b0;

  // ---------------- stage 1: operand register ----------------
  logic                v1_q;
  logic [OpW-1:0]      op1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q <= req_type_i;
    ar1_q <= a_re_i;
    ai1_q <= a_im_i;
    br1_q <= b_re_i;
    bi1_q <= b_im_i;
  end

  // ---------------- stage 2: products, add, conjugate ----------------
  logic signed [W:0]   add_re, add_im, neg_im;
  logic [W-1:0]        mag_re, mag_im;
  logic [W-1:0]        e_re_d, e_im_d;
  logic                e_sat_d;

  always_comb begin
    add_re  = {ar1_q[W-1], ar1_q} + {br1_q[W-1], br1_q};
    add_im  = {ai1_q[W-1], ai1_q} + {bi1_q[W-1], bi1_q};
    neg_im  = -{ai1_q[W-1], ai1_q};
    mag_re  = ar1_q[W-1] ? W'(-ar1_q) : W'(ar1_q);
    mag_im  = ai1_q[W-1] ? W'(-ai1_q) : W'(ai1_q);
    e_re_d  = '0;
    e_im_d  = '0;
    e_sat_d = 1'b0;
    unique case (op1_q)
      OP_ADD: begin
        if (add_re > VMAX1) begin
          e_re_d = WMAX; e_sat_d = 1'b1;
        end else if (add_re < VMIN1) begin
          e_re_d = WMIN; e_sat_d = 1'b1;
        end else begin
          e_re_d = add_re[W-1:0];
        end
        if (add_im > VMAX1) begin
          e_im_d = WMAX; e_sat_d = 1'b1;
        end else if (add_im < VMIN1) begin
          e_im_d = WMIN; e_sat_d = 1'b1;
        end else begin
          e_im_d = add_im[W-1:0];
        end
      end
      OP_CONJ: begin
        e_re_d = ar1_q;
        if (neg_im > VMAX1) begin
          e_im_d = WMAX; e_sat_d = 1'b1;
        end else begin
          e_im_d = neg_im[W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  logic                  v2_q;
  logic [OpW-1:0]        op2_q;
  logic signed [2*W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [SW-1:0]         sq_re_q, sq_im_q;
  logic [W-1:0]          mag_re2_q, mag_im2_q;
  logic                  sgn_re2_q, sgn_im2_q;
  logic [W-1:0]          e_re2_q, e_im2_q;
  logic                  e_sat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q     <= op1_q;
    p_rr_q    <= ar1_q * br1_q;
    p_ii_q    <= ai1_q * bi1_q;
    p_ri_q    <= ar1_q * bi1_q;
    p_ir_q    <= br1_q * ai1_q;
    sq_re_q   <= mag_re * mag_re;
    sq_im_q   <= mag_im * mag_im;
    mag_re2_q <= mag_re;
    mag_im2_q <= mag_im;
    sgn_re2_q <= ar1_q[W-1];
    // imaginary part of the reciprocal carries the sign of -a_im
    sgn_im2_q <= !ai1_q[W-1] && (ai1_q != '0);
    e_re2_q   <= e_re_d;
    e_im2_q   <= e_im_d;
    e_sat2_q  <= e_sat_d;
  end

  // ---------------- stage 3: sums ----------------
  logic                  v3_q;
  logic [OpW-1:0]        op3_q;
  logic signed [2*W:0]   m_re3_q, m_im3_q;
  logic [SW-1:0]         s3_q;
  logic [W-1:0]          mag_re3_q, mag_im3_q;
  logic                  sgn_re3_q, sgn_im3_q;
  logic [W-1:0]          e_re3_q, e_im3_q;
  logic                  e_sat3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q     <= op2_q;
    m_re3_q   <= {p_rr_q[2*W-1], p_rr_q} - {p_ii_q[2*W-1], p_ii_q};
    m_im3_q   <= {p_ri_q[2*W-1], p_ri_q} + {p_ir_q[2*W-1], p_ir_q};
    s3_q      <= sq_re_q + sq_im_q;
    mag_re3_q <= mag_re2_q;
    mag_im3_q <= mag_im2_q;
    sgn_re3_q <= sgn_re2_q;
    sgn_im3_q <= sgn_im2_q;
    e_re3_q   <= e_re2_q;
    e_im3_q   <= e_im2_q;
    e_sat3_q  <= e_sat2_q;
  end

  // multiply result: floor shift then clamp, folded into the early result
  logic signed [2*W:0] sh_re, sh_im;
  logic [W-1:0]        e_re4, e_im4;
  logic                e_sat4;

  always_comb begin
    sh_re  = m_re3_q >>> F;
    sh_im  = m_im3_q >>> F;
    e_re4  = e_re3_q;
    e_im4  = e_im3_q;
    e_sat4 = e_sat3_q;
    if (op3_q == OP_MUL) begin
      e_sat4 = 1'b0;
      if (sh_re > VMAX2) begin
        e_re4 = WMAX; e_sat4 = 1'b1;
      end else if (sh_re < VMIN2) begin
        e_re4 = WMIN; e_sat4 = 1'b1;
      end else begin
        e_re4 = sh_re[W-1:0];
      end
      if (sh_im > VMAX2) begin
        e_im4 = WMAX; e_sat4 = 1'b1;
      end else if (sh_im < VMIN2) begin
        e_im4 = WMIN; e_sat4 = 1'b1;
      end else begin
        e_im4 = sh_im[W-1:0];
      end
    end
  end

  // ---------------- chain of cells ----------------
  logic [NC:0][SW-1:0]   c_s;
  logic [NC:0][NC-1:0]   c_re_n, c_re_q, c_im_n, c_im_q, c_sq_q;
  logic [NC:0][SW-1:0]   c_re_r, c_im_r;
  logic [NC:0][2*NC-1:0] c_sq_n;
  logic [NC:0][NC:0]     c_sq_r;

  // numerators are |x| << 2F, radicand is zero-extended to 2*NC bits
  assign c_s[0]    = s3_q;
  assign c_re_n[0] = NC'({mag_re3_q, {(2*F){1'b0}}});
  assign c_im_n[0] = NC'({mag_im3_q, {(2*F){1'b0}}});
  assign c_re_r[0] = '0;
  assign c_im_r[0] = '0;
  assign c_re_q[0] = '0;
  assign c_im_q[0] = '0;
  assign c_sq_n[0] = (2*NC)'(s3_q);
  assign c_sq_r[0] = '0;
  assign c_sq_q[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cau_cell #(.NC(NC), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .div_s_i (c_s[k]),
      .re_n_i  (c_re_n[k]),
      .re_r_i  (c_re_r[k]),
      .re_q_i  (c_re_q[k]),
      .im_n_i  (c_im_n[k]),
      .im_r_i  (c_im_r[k]),
      .im_q_i  (c_im_q[k]),
      .sq_n_i  (c_sq_n[k]),
      .sq_r_i  (c_sq_r[k]),
      .sq_q_i  (c_sq_q[k]),
      .div_s_o (c_s[k+1]),
      .re_n_o  (c_re_n[k+1]),
      .re_r_o  (c_re_r[k+1]),
      .re_q_o  (c_re_q[k+1]),
      .im_n_o  (c_im_n[k+1]),
      .im_r_o  (c_im_r[k+1]),
      .im_q_o  (c_im_q[k+1]),
      .sq_n_o  (c_sq_n[k+1]),
      .sq_r_o  (c_sq_r[k+1]),
      .sq_q_o  (c_sq_q[k+1])
    );
  end

  // side data rides alongside the chain, one slot per cell
  logic [NC-1:0]           cv_q;
  logic [NC-1:0][OpW-1:0]  cop_q;
  logic [NC-1:0][W-1:0]    cre_q, cim_q;
  logic [NC-1:0]           csat_q, csgr_q, csgi_q, cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else begin
      cv_q <= {cv_q[NC-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    cop_q[0]  <= op3_q;
    cre_q[0]  <= e_re4;
    cim_q[0]  <= e_im4;
    csat_q[0] <= e_sat4;
    csgr_q[0] <= sgn_re3_q;
    csgi_q[0] <= sgn_im3_q;
    cz_q[0]   <= (s3_q == '0);
    for (int i = 1; i < NC; i++) begin
      cop_q[i]  <= cop_q[i-1];
      cre_q[i]  <= cre_q[i-1];
      cim_q[i]  <= cim_q[i-1];
      csat_q[i] <= csat_q[i-1];
      csgr_q[i] <= csgr_q[i-1];
      csgi_q[i] <= csgi_q[i-1];
      cz_q[i]   <= cz_q[i-1];
    end
  end

  // ---------------- output stage ----------------
  logic [NC-1:0]  qre, qim, root;
  logic [W-1:0]   o_re_d, o_im_d;
  logic [StW-1:0] o_st_d;
  logic           o_sat;

  always_comb begin
    qre    = c_re_q[NC];
    qim    = c_im_q[NC];
    root   = c_sq_q[NC];
    o_re_d = cre_q[NC-1];
    o_im_d = cim_q[NC-1];
    o_sat  = csat_q[NC-1];
    o_st_d = ST_OK;
    unique case (cop_q[NC-1])
      OP_MOD: begin
        o_im_d = '0;
        o_sat  = 1'b0;
        if (root > RMAX) begin
          o_re_d = WMAX; o_sat = 1'b1;
        end else begin
          o_re_d = root[W-1:0];
        end
      end
      OP_RECIP: begin
        o_sat = 1'b0;
        if (cz_q[NC-1]) begin
          o_re_d = '0;
          o_im_d = '0;
          o_st_d = ST_DIVZ;
        end else begin
          if (!csgr_q[NC-1] && qre > RMAX) begin
            o_re_d = WMAX; o_sat = 1'b1;
          end else if (csgr_q[NC-1] && qre > RNEG) begin
            o_re_d = WMIN; o_sat = 1'b1;
          end else begin
            o_re_d = csgr_q[NC-1] ? W'(-qre) : qre[W-1:0];
          end
          if (!csgi_q[NC-1] && qim > RMAX) begin
            o_im_d = WMAX; o_sat = 1'b1;
          end else if (csgi_q[NC-1] && qim > RNEG) begin
            o_im_d = WMIN; o_sat = 1'b1;
          end else begin
            o_im_d = csgi_q[NC-1] ? W'(-qim) : qim[W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    if (o_sat) begin
      o_st_d = ST_SAT;
    end
  end

  logic           done_q;
  logic [W-1:0]   res_re_q, res_im_q;
  logic [StW-1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cv_q[NC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= o_re_d;
    res_im_q <= o_im_d;
    status_q <= o_st_d;
  end

  assign done_o   = done_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;
  assign status_o = status_q;

  // ---------------- checks ----------------
  // every accepted word comes out after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(LAT) done_o)
    else $error("result strobe missing after request");

  // no strobe without a request the fixed latency earlier
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result strobe without request");

  // divide-by-zero always returns zero parts
  a_divz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_DIVZ) |-> (res_re_o == '0 && res_im_o == '0))
    else $error("reciprocal of zero with nonzero result");

  // modulus result is never negative and has no imaginary part
  a_mod_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv_q[NC-1] && cop_q[NC-1] == OP_MOD) |=> (!res_re_o[W-1] && res_im_o == '0))
    else $error("malformed modulus result");

endmodule
